// File: hdl/cps_pkg.sv
package cps_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_GRID_COLS   = 64;
    localparam int DEF_GRID_ROWS   = 32;
    localparam int DEF_STACK_DEPTH = 8;

    // Fixed field widths
    localparam int MODE_W    = 2;
    localparam int COL_W     = 6;
    localparam int ROW_W     = 5;
    localparam int CHAR_W    = 8;
    localparam int COUNT_W   = 4;
    localparam int GWIDTH_W  = 7;
    localparam int GHEIGHT_W = 6;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // row * width + col needs this many bits before it is cut to the cell index
    localparam int CELL_SUM_W = ROW_W + GWIDTH_W + 1;

    // Register reset values
    localparam logic [GWIDTH_W-1:0]  GWIDTH_RST  = 7'd64;
    localparam logic [GHEIGHT_W-1:0] GHEIGHT_RST = 6'd32;

    // Characters with a meaning of their own
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    // Request modes
    typedef enum logic [MODE_W-1:0] {
        MODE_ADD  = 2'd0,
        MODE_REM  = 2'd1,
        MODE_POP  = 2'd2,
        MODE_PEEK = 2'd3
    } t_mode;

    // Register index taken from paddr[2]
    typedef enum logic {
        REG_GWIDTH  = 1'b0,
        REG_GHEIGHT = 1'b1
    } t_reg_idx;

    // Status produced by the stack update
    typedef struct packed {
        logic dropped;
        logic found;
    } t_alu_flags;

    // Class priority: letter 3, digit 2, dot or star 1, anything else 0
    function automatic logic [1:0] char_class(input logic [CHAR_W-1:0] c);
        logic [1:0] cls;
        if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
            cls = 2'd3;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            cls = 2'd2;
        end else if (c == CHAR_DOT || c == CHAR_STAR) begin
            cls = 2'd1;
        end else begin
            cls = 2'd0;
        end
        return cls;
    endfunction

endpackage

// File: hdl/cps_if.sv
// Request channel
interface cps_req_if import cps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [CHAR_W-1:0] char_in;

    modport source (output valid, mode, col, row, char_in, input ready);
    modport sink   (input valid, mode, col, row, char_in, output ready);
endinterface

// Response channel
interface cps_rsp_if import cps_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CHAR_W-1:0]  shown_char;
    logic [COUNT_W-1:0] stack_count;
    logic               dropped;
    logic               found;
    logic               bad_coordinate;

    modport source (output valid, shown_char, stack_count, dropped, found, bad_coordinate,
                    input ready);
    modport sink   (input valid, shown_char, stack_count, dropped, found, bad_coordinate,
                    output ready);
endinterface

// File: hdl/cps_apb_regs.sv
module cps_apb_regs import cps_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready,
    output logic [GWIDTH_W-1:0]  o_grid_width,
    output logic [GHEIGHT_W-1:0] o_grid_height
);

    logic [GWIDTH_W-1:0]  r_grid_width;
    logic [GHEIGHT_W-1:0] r_grid_height;
    logic                 wr_en;
    t_reg_idx             reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[2]);

    // Register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GWIDTH_RST;
            r_grid_height <= GHEIGHT_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_GWIDTH:  r_grid_width  <= pwdata[GWIDTH_W-1:0];
                REG_GHEIGHT: r_grid_height <= pwdata[GHEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back
    always_comb begin
        unique case (reg_idx)
            REG_GWIDTH:  prdata = APB_DW'(r_grid_width);
            REG_GHEIGHT: prdata = APB_DW'(r_grid_height);
            default:     prdata = '0;
        endcase
    end

    assign o_grid_width  = r_grid_width;
    assign o_grid_height = r_grid_height;

endmodule

// File: hdl/cps_cell_mem.sv
module cps_cell_mem import cps_pkg::*; #(
    parameter int NUM_CELLS   = DEF_GRID_COLS * DEF_GRID_ROWS,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    localparam int ADDR_W     = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1,
    localparam int CNT_W      = $clog2(STACK_DEPTH + 1)
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_rd_en,
    input  logic [ADDR_W-1:0]                       i_rd_addr,
    output logic [STACK_DEPTH-1:0][CHAR_W-1:0]      o_rd_stack,
    output logic [CNT_W-1:0]                        o_rd_count,
    input  logic                                    i_wr_en,
    input  logic [ADDR_W-1:0]                       i_wr_addr,
    input  logic [STACK_DEPTH-1:0][CHAR_W-1:0]      i_wr_stack,
    input  logic [CNT_W-1:0]                        i_wr_count,
    output logic                                    o_busy
);

    // One word per cell: the whole stack, and its entry count
    logic [STACK_DEPTH-1:0][CHAR_W-1:0] mem_stack [NUM_CELLS];
    logic [CNT_W-1:0]                   mem_count [NUM_CELLS];

    logic [STACK_DEPTH-1:0][CHAR_W-1:0] r_rd_stack;
    logic [CNT_W-1:0]                   r_rd_count;
    logic                               r_clr_busy;
    logic [ADDR_W-1:0]                  r_clr_addr;
    logic                               cnt_we;
    logic [ADDR_W-1:0]                  cnt_waddr;
    logic [CNT_W-1:0]                   cnt_wdata;

    // Clearing pass over the counts after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_W'(NUM_CELLS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign cnt_we    = r_clr_busy || i_wr_en;
    assign cnt_waddr = r_clr_busy ? r_clr_addr : i_wr_addr;
    assign cnt_wdata = r_clr_busy ? '0 : i_wr_count;

    // Stack memory
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_stack[i_wr_addr] <= i_wr_stack;
        end
        if (i_rd_en) begin
            r_rd_stack <= mem_stack[i_rd_addr];
        end
    end

    // Count memory
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            mem_count[cnt_waddr] <= cnt_wdata;
        end
        if (i_rd_en) begin
            r_rd_count <= mem_count[i_rd_addr];
        end
    end

    assign o_rd_stack = r_rd_stack;
    assign o_rd_count = r_rd_count;
    assign o_busy     = r_clr_busy;

endmodule

// File: hdl/cps_stack_alu.sv
module cps_stack_alu import cps_pkg::*; #(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    localparam int CNT_W      = $clog2(STACK_DEPTH + 1),
    localparam int IDX_W      = $clog2(STACK_DEPTH)
) (
    input  t_mode                               i_mode,
    input  logic [CHAR_W-1:0]                   i_char,
    input  logic [STACK_DEPTH-1:0][CHAR_W-1:0]  i_stack,
    input  logic [CNT_W-1:0]                    i_count,
    output logic [STACK_DEPTH-1:0][CHAR_W-1:0]  o_stack,
    output logic [CNT_W-1:0]                    o_count,
    output logic [CHAR_W-1:0]                   o_shown,
    output t_alu_flags                          o_flags
);

    logic [1:0]                          new_cls;
    logic [1:0]                          top_cls;
    logic [CNT_W-1:0]                    ins_pos;
    logic [CNT_W-1:0]                    rem_pos;
    logic                                rem_hit;
    logic [STACK_DEPTH-1:0][CHAR_W-1:0]  n_stack;
    logic [CNT_W-1:0]                    n_count;
    t_alu_flags                          flags;

    // Insert and remove positions
    always_comb begin
        new_cls = char_class(i_char);
        top_cls = char_class(i_stack[IDX_W'(i_count - 1'b1)]);
        ins_pos = '0;
        for (int i = 0; i < STACK_DEPTH; i++) begin
            if (CNT_W'(i) < i_count && char_class(i_stack[i]) < new_cls) begin
                ins_pos = CNT_W'(i + 1);
            end
        end
        // empty stack or top not above the new class: plain push
        if (i_count == '0 || top_cls <= new_cls) begin
            ins_pos = i_count;
        end
        rem_hit = 1'b0;
        rem_pos = '0;
        for (int i = STACK_DEPTH - 1; i >= 0; i--) begin
            if (CNT_W'(i) < i_count && i_stack[i] == i_char) begin
                rem_hit = 1'b1;
                rem_pos = CNT_W'(i);
            end
        end
    end

    // Stack update
    always_comb begin
        n_stack = i_stack;
        n_count = i_count;
        flags   = '0;
        case (i_mode)
            MODE_ADD: begin
                if (i_count >= CNT_W'(STACK_DEPTH)) begin
                    flags.dropped = 1'b1;
                end else begin
                    for (int i = 1; i < STACK_DEPTH; i++) begin
                        if (CNT_W'(i) > ins_pos) begin
                            n_stack[i] = i_stack[i-1];
                        end
                    end
                    for (int i = 0; i < STACK_DEPTH; i++) begin
                        if (CNT_W'(i) == ins_pos) begin
                            n_stack[i] = i_char;
                        end
                    end
                    n_count = i_count + 1'b1;
                end
            end
            MODE_REM: begin
                if (rem_hit) begin
                    for (int i = 0; i < STACK_DEPTH - 1; i++) begin
                        if (CNT_W'(i) >= rem_pos) begin
                            n_stack[i] = i_stack[i+1];
                        end
                    end
                    n_count     = i_count - 1'b1;
                    flags.found = 1'b1;
                end
            end
            MODE_POP: begin
                if (i_count != '0) begin
                    n_count     = i_count - 1'b1;
                    flags.found = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Character now shown
    always_comb begin
        o_shown = CHAR_SPACE;
        if (i_mode == MODE_PEEK) begin
            if (n_count >= CNT_W'(2)) begin
                o_shown = n_stack[IDX_W'(n_count - CNT_W'(2))];
            end
        end else if (n_count != '0) begin
            o_shown = n_stack[IDX_W'(n_count - 1'b1)];
        end
    end

    assign o_stack = n_stack;
    assign o_count = n_count;
    assign o_flags = flags;

endmodule

// File: hdl/per_cell_priority_char_stack.sv
// Grid of character cells, each holding a stack of up to STACK_DEPTH characters kept in
// class-priority order (letters over digits over dot and star over the rest). Each request
// (add, remove by value, pop, peek below top) first reads the cell's stack word and count
// from memory; S_CALC then updates them and writes them back (not for a peek or a bad
// coordinate), waiting while the output register is full. The next request is taken after
// the write-back, so requests to the same cell never overlap. A finished response waits in
// an output register while the next request is read. After reset the count memory is
// cleared one cell a cycle, during which no request is taken; register writes are taken
// throughout. Configure the grid only while the block is idle.
module per_cell_priority_char_stack import cps_pkg::*; #(
    parameter int GRID_COLS   = DEF_GRID_COLS,
    parameter int GRID_ROWS   = DEF_GRID_ROWS,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cps_req_if.sink           i_req,
    cps_rsp_if.source         o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int NUM_CELLS = GRID_COLS * GRID_ROWS;
    localparam int ADDR_W    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int CNT_W     = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_CALC = 2'b10
    } t_state;

    t_state                              r_state, n_state;
    logic [GWIDTH_W-1:0]                 grid_width;
    logic [GHEIGHT_W-1:0]                grid_height;
    logic [GWIDTH_W-1:0]                 cols_used;
    logic [GHEIGHT_W-1:0]                rows_used;
    logic [CELL_SUM_W-1:0]               cell_sum;
    logic [ADDR_W-1:0]                   cell_addr;
    logic                                bad_coord;
    logic                                req_acc;
    logic                                out_free;
    logic                                wr_en;
    logic                                mem_busy;
    logic [STACK_DEPTH-1:0][CHAR_W-1:0]  rd_stack;
    logic [CNT_W-1:0]                    rd_count;
    logic [STACK_DEPTH-1:0][CHAR_W-1:0]  upd_stack;
    logic [CNT_W-1:0]                    upd_count;
    logic [CHAR_W-1:0]                   upd_shown;
    t_alu_flags                          upd_flags;

    // Captured request
    t_mode                               r_mode;
    logic [CHAR_W-1:0]                   r_char;
    logic                                r_bad;
    logic [ADDR_W-1:0]                   r_addr;

    // Output register
    logic                                r_out_valid;
    logic [CHAR_W-1:0]                   r_out_shown;
    logic [CNT_W-1:0]                    r_out_count;
    t_alu_flags                          r_out_flags;
    logic                                r_out_bad;

    cps_apb_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_grid_width  (grid_width),
        .o_grid_height (grid_height)
    );

    // Grid clamp, coordinate check and cell index
    always_comb begin
        cols_used = (int'(grid_width) < GRID_COLS) ? grid_width : GWIDTH_W'(GRID_COLS);
        rows_used = (int'(grid_height) < GRID_ROWS) ? grid_height : GHEIGHT_W'(GRID_ROWS);
        bad_coord = (GWIDTH_W'(i_req.col) >= cols_used) ||
                    (GHEIGHT_W'(i_req.row) >= rows_used);
        cell_sum  = CELL_SUM_W'(i_req.row) * CELL_SUM_W'(cols_used) + CELL_SUM_W'(i_req.col);
        cell_addr = ADDR_W'(cell_sum);
    end

    assign i_req.ready = (r_state == S_IDLE) && !mem_busy;
    assign req_acc     = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign wr_en       = (r_state == S_CALC) && out_free && !r_bad && (r_mode != MODE_PEEK);

    cps_cell_mem #(
        .NUM_CELLS   (NUM_CELLS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (req_acc),
        .i_rd_addr  (cell_addr),
        .o_rd_stack (rd_stack),
        .o_rd_count (rd_count),
        .i_wr_en    (wr_en),
        .i_wr_addr  (r_addr),
        .i_wr_stack (upd_stack),
        .i_wr_count (upd_count),
        .o_busy     (mem_busy)
    );

    cps_stack_alu #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_alu (
        .i_mode  (r_mode),
        .i_char  (r_char),
        .i_stack (rd_stack),
        .i_count (rd_count),
        .o_stack (upd_stack),
        .o_count (upd_count),
        .o_shown (upd_shown),
        .o_flags (upd_flags)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (req_acc) n_state = S_CALC;
            S_CALC: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_mode <= t_mode'(i_req.mode);
            r_char <= i_req.char_in;
            r_bad  <= bad_coord;
            r_addr <= cell_addr;
        end
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_CALC && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CALC && out_free) begin
            if (r_bad) begin
                r_out_shown <= CHAR_SPACE;
                r_out_count <= '0;
                r_out_flags <= '0;
                r_out_bad   <= 1'b1;
            end else begin
                r_out_shown <= upd_shown;
                r_out_count <= upd_count;
                r_out_flags <= upd_flags;
                r_out_bad   <= 1'b0;
            end
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.shown_char     = r_out_shown;
    assign o_rsp.stack_count    = COUNT_W'(r_out_count);
    assign o_rsp.dropped        = r_out_flags.dropped;
    assign o_rsp.found          = r_out_flags.found;
    assign o_rsp.bad_coordinate = r_out_bad;

endmodule
